FILE: sv/dlu_pkg.sv
// ----------------------------------------------------------------------------
// dlu_pkg: shared types and constants for the dense LU factorization unit
// Command codes, status codes, sequencer states and the ctrl/datapath bundles.
// ----------------------------------------------------------------------------
package dlu_pkg;

	localparam int MaxN   = 64;
	localparam int IdxW   = $clog2(MaxN);
	localparam int AddrW  = 2 * IdxW;
	localparam int SizeW  = 7;
	localparam int DataW  = 32;

	localparam logic [1:0] CmdLoad   = 2'd0;
	localparam logic [1:0] CmdFactor = 2'd1;
	localparam logic [1:0] CmdRead   = 2'd2;
	localparam logic [1:0] CmdNop    = 2'd3;

	localparam logic [1:0] StOk   = 2'd0;
	localparam logic [1:0] StZero = 2'd1;
	localparam logic [1:0] StSat  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PIV_RD,    // issue read of pivot (k,k)
		S_PIV_CHK,   // pivot data valid
		S_MUL_RD,    // issue read of (i,k)
		S_DIV,       // divider running
		S_MUL_WR,    // write multiplier to (i,k)
		S_UPD_RD,    // issue reads of (k,j) and (i,j)
		S_UPD_MUL,   // product
		S_UPD_WR,    // subtract, saturate, write (i,j)
		S_DONE
	} state_t;

	typedef struct packed {
		logic            piv_load;   // latch read data as pivot
		logic            div_start;  // start division of read data by pivot
		logic            mul_wr;     // write multiplier at (i,k)
		logic            rd_upd;     // read (k,j) and (i,j)
		logic            prod_en;    // register product
		logic            upd_wr;     // write reduced entry
		logic [IdxW-1:0] k;
		logic [IdxW-1:0] i;
		logic [IdxW-1:0] j;
		logic            rd_piv;     // read (k,k)
		logic            rd_ik;      // read (i,k)
		logic            clr_sat;
	} cmd_t;

	typedef struct packed {
		logic piv_zero;
		logic div_done;
		logic sat;
	} stat_t;

endpackage

FILE: sv/dlu_div.sv
// ----------------------------------------------------------------------------
// dlu_div: serial restoring divider
// (a * 65536) / b truncated toward zero, saturated to 32 bits; one bit a cycle.
// ----------------------------------------------------------------------------
module dlu_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [dlu_pkg::DataW-1:0] num,
	input  logic signed [dlu_pkg::DataW-1:0] den,
	output logic                            done,
	output logic signed [dlu_pkg::DataW-1:0] quot,
	output logic                            sat
);
	localparam int NW = 48;
	logic [NW-1:0] n_q;      // dividend magnitude, shifts out
	logic [NW-1:0] q_q;
	logic [31:0]   r_q;
	logic [31:0]   d_q;
	logic          neg_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [33:0]   trial;
	logic [32:0]   rsh;
	logic signed [NW:0] sq;

	assign rsh   = {r_q, n_q[NW-1]};
	assign trial = {1'b0, rsh} - {2'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
			d_q   <= den[31] ? 32'(-den) : 32'(den);
			neg_q <= num[31] ^ den[31];
			r_q   <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (!trial[33]) begin
				r_q <= trial[31:0];
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= rsh[31:0];
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign sq = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
	always_comb begin
		sat  = 1'b0;
		quot = 32'(sq);
		if (sq > $signed(49'sh7FFFFFFF)) begin
			sat  = 1'b1;
			quot = 32'sh7FFFFFFF;
		end else if (sq < -$signed(49'sh80000000)) begin
			sat  = 1'b1;
			quot = 32'sh80000000;
		end
	end
endmodule

FILE: sv/dlu_datapath.sv
// ----------------------------------------------------------------------------
// dlu_datapath: matrix store, divider, multiply-subtract unit
// Two-read-port store; the update path reads (k,j) and (i,j) together.
// ----------------------------------------------------------------------------
module dlu_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dlu_pkg::cmd_t                    cmd,
	output dlu_pkg::stat_t                   st,
	input  logic                             ext_we,
	input  logic [dlu_pkg::AddrW-1:0]        ext_addr,
	input  logic [dlu_pkg::DataW-1:0]        ext_wdata,
	output logic [dlu_pkg::DataW-1:0]        rd_a
);
	localparam int Depth = dlu_pkg::MaxN * dlu_pkg::MaxN;
	logic [dlu_pkg::DataW-1:0] mem [Depth];
	logic [dlu_pkg::DataW-1:0] rd_b;
	logic [dlu_pkg::AddrW-1:0] ra, rb, wa;
	logic [dlu_pkg::DataW-1:0] wd;
	logic                      we;
	logic signed [31:0] piv_q, m_q;
	logic signed [63:0] prod_s2;
	logic signed [31:0] aij_s2;
	logic signed [31:0] quot;
	logic               dsat, sat_q;
	logic signed [48:0] diff;
	logic signed [31:0] dsat_v;
	logic               usat;

	always_comb begin
		ra = ext_addr;
		rb = {cmd.i, cmd.j};
		if (cmd.rd_piv) ra = {cmd.k, cmd.k};
		else if (cmd.rd_ik) ra = {cmd.i, cmd.k};
		else if (cmd.rd_upd) ra = {cmd.k, cmd.j};
	end

	always_comb begin
		we = ext_we;
		wa = ext_addr;
		wd = ext_wdata;
		if (cmd.mul_wr) begin
			we = 1'b1; wa = {cmd.i, cmd.k}; wd = quot;
		end else if (cmd.upd_wr) begin
			we = 1'b1; wa = {cmd.i, cmd.j}; wd = dsat_v;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_a <= mem[ra];
		rd_b <= mem[rb];
	end

	dlu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start), .num(rd_a), .den(piv_q),
		.done(st.div_done), .quot(quot), .sat(dsat)
	);

	always_ff @(posedge clk) begin
		if (cmd.piv_load) piv_q <= rd_a;
		if (cmd.mul_wr) m_q <= quot;
		if (cmd.prod_en) begin
			prod_s2 <= m_q * $signed(rd_a);
			aij_s2  <= $signed(rd_b);
		end
	end

	// floor shift then exact subtract
	assign diff = 49'(aij_s2) - 49'(prod_s2 >>> 16);
	always_comb begin
		usat   = 1'b0;
		dsat_v = 32'(diff);
		if (diff > 49'sh7FFFFFFF) begin
			usat = 1'b1; dsat_v = 32'sh7FFFFFFF;
		end else if (diff < -49'sh80000000) begin
			usat = 1'b1; dsat_v = 32'sh80000000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sat_q <= 1'b0;
		else if (cmd.clr_sat) sat_q <= 1'b0;
		else if ((cmd.mul_wr && dsat) || (cmd.upd_wr && usat)) sat_q <= 1'b1;
	end

	assign st.piv_zero = (rd_a == '0);
	assign st.sat      = sat_q;
endmodule

FILE: sv/dlu_ctrl.sv
// ----------------------------------------------------------------------------
// dlu_ctrl: factoring sequencer
// Walks k, i, j and drives the datapath; reports final status.
// ----------------------------------------------------------------------------
module dlu_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [dlu_pkg::SizeW-1:0]     n_cfg,
	input  dlu_pkg::stat_t                st,
	output dlu_pkg::cmd_t                 cmd,
	output logic                          busy,
	output logic                          fin,
	output logic [1:0]                    fin_status
);
	dlu_pkg::state_t state_q, state_d;
	logic [dlu_pkg::IdxW:0] k_q, i_q, j_q, k_d, i_d, j_d, n;
	logic [1:0] fst_q, fst_d;
	logic div_go_q;

	assign n = (n_cfg > dlu_pkg::SizeW'(dlu_pkg::MaxN)) ?
		(dlu_pkg::IdxW+1)'(dlu_pkg::MaxN) : (dlu_pkg::IdxW+1)'(n_cfg);

	always_comb begin
		state_d = state_q;
		k_d = k_q; i_d = i_q; j_d = j_q; fst_d = fst_q;
		case (state_q)
			dlu_pkg::S_IDLE: if (go) begin
				k_d = '0;
				if (n < 2) begin
					fst_d = dlu_pkg::StOk; state_d = dlu_pkg::S_DONE;
				end else state_d = dlu_pkg::S_PIV_RD;
			end
			dlu_pkg::S_PIV_RD: state_d = dlu_pkg::S_PIV_CHK;
			dlu_pkg::S_PIV_CHK: begin
				if (st.piv_zero) begin
					fst_d = dlu_pkg::StZero; state_d = dlu_pkg::S_DONE;
				end else begin
					i_d = k_q + 1'b1; state_d = dlu_pkg::S_MUL_RD;
				end
			end
			dlu_pkg::S_MUL_RD: state_d = dlu_pkg::S_DIV;
			dlu_pkg::S_DIV: if (st.div_done) state_d = dlu_pkg::S_MUL_WR;
			dlu_pkg::S_MUL_WR: begin
				j_d = k_q + 1'b1; state_d = dlu_pkg::S_UPD_RD;
			end
			dlu_pkg::S_UPD_RD: state_d = dlu_pkg::S_UPD_MUL;
			dlu_pkg::S_UPD_MUL: state_d = dlu_pkg::S_UPD_WR;
			dlu_pkg::S_UPD_WR: begin
				if (j_q + 1 < n) begin
					j_d = j_q + 1'b1; state_d = dlu_pkg::S_UPD_RD;
				end else if (i_q + 1 < n) begin
					i_d = i_q + 1'b1; state_d = dlu_pkg::S_MUL_RD;
				end else if (k_q + 2 < n) begin
					k_d = k_q + 1'b1; state_d = dlu_pkg::S_PIV_RD;
				end else begin
					state_d = dlu_pkg::S_DONE;
					fst_d = st.sat ? dlu_pkg::StSat : dlu_pkg::StOk;
				end
			end
			dlu_pkg::S_DONE: state_d = dlu_pkg::S_IDLE;
			default: state_d = dlu_pkg::S_IDLE;
		endcase
	end

	// the last write's saturation lands in sat_q the same edge we leave; check it late
	always_comb begin
		cmd = '0;
		cmd.k = k_q[dlu_pkg::IdxW-1:0];
		cmd.i = i_q[dlu_pkg::IdxW-1:0];
		cmd.j = j_q[dlu_pkg::IdxW-1:0];
		case (state_q)
			dlu_pkg::S_IDLE:    cmd.clr_sat = go;
			dlu_pkg::S_PIV_RD:  cmd.rd_piv = 1'b1;
			dlu_pkg::S_PIV_CHK: cmd.piv_load = 1'b1;
			dlu_pkg::S_MUL_RD:  cmd.rd_ik = 1'b1;
			dlu_pkg::S_MUL_WR:  cmd.mul_wr = 1'b1;
			dlu_pkg::S_UPD_RD:  cmd.rd_upd = 1'b1;
			dlu_pkg::S_UPD_MUL: cmd.prod_en = 1'b1;
			dlu_pkg::S_UPD_WR:  cmd.upd_wr = 1'b1;
			default: ;
		endcase
		// divider starts the cycle after the (i,k) read is issued, when rd_a holds it
		cmd.div_start = div_go_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlu_pkg::S_IDLE;
			k_q <= '0; i_q <= '0; j_q <= '0;
			fst_q <= dlu_pkg::StOk;
			div_go_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q <= k_d; i_q <= i_d; j_q <= j_d;
			fst_q <= fst_d;
			div_go_q <= (state_q == dlu_pkg::S_MUL_RD);
		end
	end

	logic [1:0] late;
	assign late = (fst_q == dlu_pkg::StOk && st.sat) ? dlu_pkg::StSat : fst_q;
	assign busy = (state_q != dlu_pkg::S_IDLE);
	assign fin = (state_q == dlu_pkg::S_DONE);
	assign fin_status = late;
endmodule

FILE: sv/dense_lu_factorization_unit.sv
// ----------------------------------------------------------------------------
// dense_lu_factorization_unit: in-place Q16.16 LU (Doolittle, no pivoting)
// Command channel in, one result item out per command.
// ----------------------------------------------------------------------------
// Use: drive command/row/col/value with valid; each accepted item yields one
// result item (data, status) on the output channel.
// Load: result valid the cycle after acceptance; loads stream one per cycle
// while results are taken.
// Read: store read is registered, then the data is placed in the output
// register; input is held off while the read is pending.
// Factor: the sequencer walks pivots k, rows i, columns j. Each pivot is read,
// then checked. Each multiplier goes through the (i,k) read, the divider start,
// 48 division steps, the quotient cycle and the write. Each trailing update
// steps through read, multiply and subtract/write. A done state follows,
// after which the result is valid; input is held off meanwhile.
// Status reports the last factor outcome (0 ok, 1 zero pivot, 2 saturation).
// Reset: clears status to ok and size to 64; the store is undefined.
// Stall: a result waiting in the output register holds off the input until
// it is taken; nothing is accepted while a result cannot be placed.
// ----------------------------------------------------------------------------
module dense_lu_factorization_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] data,
	output logic [1:0]         status,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata
);
	logic [6:0] size_q;
	logic [1:0] last_q;
	dlu_pkg::cmd_t  cmd;
	dlu_pkg::stat_t st;
	logic busy, fin;
	logic [1:0] fst;
	logic acc, rd_pend_q;
	logic [31:0] rd_a;

	// accept when nothing is in flight and the output slot is free or draining
	assign in_ready = !busy && !rd_pend_q && (!out_valid || out_ready);
	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= 7'd64;
		else if (cfg_we) size_q <= cfg_wdata;
	end

	dlu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(acc && command == dlu_pkg::CmdFactor),
		.n_cfg(size_q), .st(st), .cmd(cmd), .busy(busy), .fin(fin), .fin_status(fst)
	);

	dlu_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.ext_we(acc && command == dlu_pkg::CmdLoad),
		.ext_addr({row, col}), .ext_wdata(value), .rd_a(rd_a)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
			out_valid <= 1'b0;
			last_q    <= dlu_pkg::StOk;
			data      <= '0;
			status    <= dlu_pkg::StOk;
		end else begin
			rd_pend_q <= acc && command == dlu_pkg::CmdRead;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (acc && (command == dlu_pkg::CmdLoad || command == dlu_pkg::CmdNop)) begin
				out_valid <= 1'b1;
				data      <= '0;
				status    <= last_q;
			end
			if (rd_pend_q) begin
				out_valid <= 1'b1;
				data      <= rd_a;
				status    <= last_q;
			end
			if (fin) begin
				last_q    <= fst;
				out_valid <= 1'b1;
				data      <= '0;
				status    <= fst;
			end
		end
	end
endmodule

FILE: sv/dlu_checker.sv
// ----------------------------------------------------------------------------
// dlu_checker: port-level checks for the LU unit
// Watches the handshakes and result fields.
// ----------------------------------------------------------------------------
module dlu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  command,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] data,
	input logic [1:0]  status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status))
		else $error("result changed under stall");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == dlu_pkg::CmdLoad |=> out_valid && data == '0)
		else $error("load result wrong");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == dlu_pkg::CmdFactor |=> !in_ready)
		else $error("accepted during factor");
endmodule

bind dense_lu_factorization_unit dlu_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.command(command), .out_valid(out_valid), .out_ready(out_ready),
	.data(data), .status(status)
);

FILE: tb/dense_lu_factorization_unit_tb.sv
// ----------------------------------------------------------------------------
// dense_lu_factorization_unit_tb: self-checking bench for the LU unit
// Streams load/read/factor/no-op items through the command channel. An
// in-bench Q16.16 Doolittle model predicts each result; results are checked
// field by field in order. Idling, output stalls (one of them long) and size changes vary.
// ----------------------------------------------------------------------------
module dense_lu_factorization_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [1:0]         cmd;
		logic [5:0]         r;
		logic [5:0]         c;
		logic signed [31:0] v;
	} lu_item_t;

	typedef struct {
		logic signed [31:0] d;
		logic [1:0]         st;
	} lu_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         command = dlu_pkg::CmdLoad;
	logic [5:0]         row = '0;
	logic [5:0]         col = '0;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] data;
	logic [1:0]         status;
	logic               cfg_we = 1'b0;
	logic [6:0]         cfg_wdata = '0;

	// pending items, expected results
	lu_item_t   cmd_queue[$];
	lu_result_t result_queue[$];

	// predictor state: store, status, active size
	int         store_mirror[dlu_pkg::MaxN*dlu_pkg::MaxN];
	logic [1:0] status_mirror = dlu_pkg::StOk;
	int         size_mirror = 64;

	int errors = 0;
	int send_idle_pct = 22;
	int recv_idle_pct = 71;
	bit long_hold_req = 1'b0;

	// generator-side view of what has been loaded (reads only touch these)
	bit loaded[dlu_pkg::MaxN*dlu_pkg::MaxN];
	int loaded_list[$];
	int item_count = 0;

	dense_lu_factorization_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.row      (row),
		.col      (col),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data     (data),
		.status   (status),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp32(longint x, inout bit s);
		if (x > 64'sd2147483647) begin
			s = 1'b1;
			return 32'sh7FFFFFFF;
		end
		if (x < -64'sd2147483648) begin
			s = 1'b1;
			return 32'sh80000000;
		end
		return int'(x);
	endfunction

	// in-place Doolittle on the mirror store, returns the new status
	function automatic logic [1:0] lu_factor(int n);
		bit     s;
		int     piv;
		int     mult;
		longint prod;
		s = 1'b0;
		if (n > dlu_pkg::MaxN)
			n = dlu_pkg::MaxN;
		for (int k = 0; k + 1 < n; k++) begin
			piv = store_mirror[k*dlu_pkg::MaxN+k];
			if (piv == 0)
				return dlu_pkg::StZero;
			for (int i = k + 1; i < n; i++) begin
				// signed 64-bit divide truncates toward zero
				mult = clamp32((longint'(store_mirror[i*dlu_pkg::MaxN+k]) * 65536) /
					longint'(piv), s);
				store_mirror[i*dlu_pkg::MaxN+k] = mult;
				for (int j = k + 1; j < n; j++) begin
					// arithmetic shift = floor of Q16 product
					prod = (longint'(mult) *
						longint'(store_mirror[k*dlu_pkg::MaxN+j])) >>> 16;
					store_mirror[i*dlu_pkg::MaxN+j] =
						clamp32(longint'(store_mirror[i*dlu_pkg::MaxN+j]) - prod, s);
				end
			end
		end
		return s ? dlu_pkg::StSat : dlu_pkg::StOk;
	endfunction

	// driver: keeps valid/payload stable until the item is taken
	always @(posedge clk) begin
		lu_item_t it;
		if (arst_n && (!in_valid || in_ready)) begin
			if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				it = cmd_queue.pop_front();
				command  <= it.cmd;
				row      <= it.r;
				col      <= it.c;
				value    <= it.v;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stall plus one long hold-off on request
	int  hold_cnt = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (long_hold_req && !hold_done) begin
			hold_cnt  <= 300;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: predict on input accept, check on output accept
	always @(posedge clk) begin
		lu_result_t exp_r;
		lu_result_t res;
		if (arst_n && in_valid && in_ready) begin
			res.d = '0;
			case (command)
				dlu_pkg::CmdLoad:   store_mirror[{row, col}] = value;
				dlu_pkg::CmdFactor: status_mirror = lu_factor(size_mirror);
				dlu_pkg::CmdRead:   res.d = store_mirror[{row, col}];
				default:   ;
			endcase
			res.st = status_mirror;
			result_queue.push_back(res);
		end
		if (arst_n && out_valid && out_ready) begin
			if (result_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected result data=%h status=%0d", $time, data, status);
			end else begin
				exp_r = result_queue.pop_front();
				if (data !== exp_r.d) begin
					errors++;
					$display("%0t: data mismatch expected %h actual %h", $time, exp_r.d, data);
				end
				if (status !== exp_r.st) begin
					errors++;
					$display("%0t: status mismatch expected %0d actual %0d",
						$time, exp_r.st, status);
				end
			end
		end
	end

	// watchdog: cycles with work outstanding but no handshake
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
			(cmd_queue.size() == 0 && !in_valid && result_queue.size() == 0))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 60000) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic put(logic [1:0] cmd, int r, int c, int v);
		lu_item_t it;
		it.cmd = cmd;
		it.r = r[5:0];
		it.c = c[5:0];
		it.v = v;
		cmd_queue.push_back(it);
		item_count++;
		if (cmd == dlu_pkg::CmdLoad && !loaded[r*dlu_pkg::MaxN+c]) begin
			loaded[r*dlu_pkg::MaxN+c] = 1'b1;
			loaded_list.push_back(r*dlu_pkg::MaxN+c);
		end
	endtask

	task automatic read_any();
		int a;
		a = loaded_list[$urandom_range(loaded_list.size()-1)];
		put(dlu_pkg::CmdRead, a / dlu_pkg::MaxN, a % dlu_pkg::MaxN, 0);
	endtask

	// sample at the falling edge so the driver's and monitor's updates have settled
	task automatic drain();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || in_valid || result_queue.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	// size write only when the block is idle
	task automatic set_size(int n);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= n[6:0];
		size_mirror = n;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// load an n x n matrix; kind 0 well-conditioned, 1 wild, 2 with diagonal entries randomly zeroed
	task automatic load_matrix(int n, int kind);
		int v;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++) begin
				if (kind == 1)
					v = $urandom;
				else if (r == c)
					v = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(4*n, 16*n) << 16);
				else
					v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
				if (kind == 2 && r == c && r == $urandom_range(n-1))
					v = 0;
				put(dlu_pkg::CmdLoad, r, c, v);
				if ($urandom_range(9) == 0)
					put(dlu_pkg::CmdLoad, $urandom_range(63), $urandom_range(63), $urandom);
			end
	endtask

	initial begin
		int n;
		int kind;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, each command, special cases
		set_size(2);
		put(dlu_pkg::CmdLoad, 63, 63, 32'sh80000000);
		put(dlu_pkg::CmdLoad, 0, 63, 32'sh7FFFFFFF);
		put(dlu_pkg::CmdRead, 63, 63, 0);
		put(dlu_pkg::CmdRead, 0, 63, 0);
		put(dlu_pkg::CmdNop, 63, 63, -1);
		put(dlu_pkg::CmdLoad, 0, 0, 2 << 16);
		put(dlu_pkg::CmdLoad, 0, 1, 1 << 16);
		put(dlu_pkg::CmdLoad, 1, 0, 1 << 16);
		put(dlu_pkg::CmdLoad, 1, 1, 3 << 16);
		put(dlu_pkg::CmdFactor, 0, 0, 0);
		put(dlu_pkg::CmdRead, 1, 0, 0);
		put(dlu_pkg::CmdRead, 1, 1, 0);
		// multiplier overflow -> saturation status
		put(dlu_pkg::CmdLoad, 0, 0, 1);
		put(dlu_pkg::CmdLoad, 1, 0, 32'sh7FFFFFFF);
		put(dlu_pkg::CmdFactor, 0, 0, 0);
		put(dlu_pkg::CmdRead, 1, 0, 0);
		put(dlu_pkg::CmdNop, 0, 0, 0);
		// zero pivot at the first row
		put(dlu_pkg::CmdLoad, 0, 0, 0);
		put(dlu_pkg::CmdFactor, 0, 0, 0);
		put(dlu_pkg::CmdRead, 1, 1, 0);
		// oversized and full-size settings stop at the zero pivot
		set_size(127);
		put(dlu_pkg::CmdFactor, 0, 0, 0);
		set_size(64);
		put(dlu_pkg::CmdFactor, 0, 0, 0);
		// sizes below two change nothing and report ok
		set_size(0);
		put(dlu_pkg::CmdFactor, 0, 0, 0);
		set_size(1);
		put(dlu_pkg::CmdFactor, 0, 0, 0);
		put(dlu_pkg::CmdRead, 0, 0, 0);
		// one mid-size factor
		set_size(16);
		load_matrix(16, 0);
		put(dlu_pkg::CmdFactor, 0, 0, 0);
		for (int q = 0; q < 8; q++)
			read_any();
		drain();

		// random phases; idle pattern moves through three modes
		long_hold_req <= 1'b1;
		while (item_count < 700) begin
			if (item_count < 260) begin
				send_idle_pct <= 22;
				recv_idle_pct <= 71;
			end else if (item_count < 480) begin
				send_idle_pct <= 71;
				recv_idle_pct <= 22;
			end else begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			n = $urandom_range(2, 7);
			kind = $urandom_range(5);
			kind = (kind < 4) ? 0 : kind - 3;
			set_size(n);
			load_matrix(n, kind);
			for (int q = $urandom_range(3); q > 0; q--)
				read_any();
			if ($urandom_range(7) == 0)
				put(dlu_pkg::CmdNop, $urandom_range(63), $urandom_range(63), $urandom);
			put(dlu_pkg::CmdFactor, $urandom_range(63), $urandom_range(63), $urandom);
			for (int q = n * n / 2 + 1; q > 0; q--)
				read_any();
		end
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
sv/dlu_pkg.sv
sv/dlu_div.sv
sv/dlu_datapath.sv
sv/dlu_ctrl.sv
sv/dense_lu_factorization_unit.sv
sv/dlu_checker.sv
tb/dense_lu_factorization_unit_tb.sv
